/* design/mia_pkg.sv */
// ----------------------------------------------------------------------------
// mia_pkg
// Shared types and constants for the integer ALU execute block: operation
// codes, field widths and the write-back record.
// ----------------------------------------------------------------------------
package mia_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 5;
    localparam int REG_COUNT = 1 << IDX_W;
    localparam int OP_W      = 5;
    localparam int SHAMT_W   = 5;
    localparam int IMM_W     = 16;

    // shift amounts are taken modulo the word width
    localparam logic [SHAMT_W-1:0] SHIFT_MASK = 5'h1F;
    // lui places the immediate in the upper half
    localparam int                 LUI_SHIFT  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_NOP   = 5'd0,
        OP_SLL   = 5'd1,
        OP_SRL   = 5'd2,
        OP_SRA   = 5'd3,
        OP_SLLV  = 5'd4,
        OP_SRLV  = 5'd5,
        OP_SRAV  = 5'd6,
        OP_ADDU  = 5'd7,
        OP_SUBU  = 5'd8,
        OP_AND   = 5'd9,
        OP_OR    = 5'd10,
        OP_XOR   = 5'd11,
        OP_NOR   = 5'd12,
        OP_SLT   = 5'd13,
        OP_SLTU  = 5'd14,
        OP_ADDIU = 5'd15,
        OP_SLTI  = 5'd16,
        OP_SLTIU = 5'd17,
        OP_ANDI  = 5'd18,
        OP_ORI   = 5'd19,
        OP_XORI  = 5'd20,
        OP_LUI   = 5'd21
    } alu_op_t;

    // one register write-back
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } wr_t;

endpackage

/* design/mips_integer_alu_with_register_file.sv */
// ----------------------------------------------------------------------------
// mips_integer_alu_with_register_file
// Integer ALU execute stage with a 32 x 32 register file and write-back
// reporting; one instruction per item, one write-back item out per item.
// ----------------------------------------------------------------------------
// Usage: the block takes one instruction item per cycle while the output side
// is not stalled and returns one write-back item for each, in order. The
// accepting edge reads the register file into registered read ports, with a
// bypass from the write that lands on the same edge. In the following cycle
// the ALU runs, and the edge at which the item leaves the read stage writes
// the result both into the register file and into the output register, from
// which the write-back item is offered, so an instruction always sees the
// results of every earlier one. Sustained rate is one item per cycle, limited
// only by output back-pressure. Register file contents read as zero after
// reset without any clearing pass.
module mips_integer_alu_with_register_file (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mia_pkg::OP_W-1:0]     s_mode,
    input  logic [mia_pkg::IDX_W-1:0]    s_src_reg,
    input  logic [mia_pkg::IDX_W-1:0]    s_tgt_reg,
    input  logic [mia_pkg::IDX_W-1:0]    s_dst_reg,
    input  logic [mia_pkg::SHAMT_W-1:0]  s_shift_amount,
    input  logic [mia_pkg::IMM_W-1:0]    s_immediate,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_write_enable,
    output logic [mia_pkg::IDX_W-1:0]    m_write_index,
    output logic [mia_pkg::DATA_W-1:0]   m_write_value
);
    import mia_pkg::*;

    // read stage
    logic                a_valid_reg;
    logic [OP_W-1:0]     a_mode_reg;
    logic [IDX_W-1:0]    a_rt_idx_reg;
    logic [IDX_W-1:0]    a_rd_idx_reg;
    logic [SHAMT_W-1:0]  a_shamt_reg;
    logic [IMM_W-1:0]    a_imm_reg;

    // output stage
    logic                m_valid_reg;
    wr_t                 m_wb_reg;

    logic                s_accept;
    logic                a_adv;
    logic [DATA_W-1:0]   rs_data;
    logic [DATA_W-1:0]   rt_data;
    wr_t                 alu_res;
    wr_t                 rf_wr;

    // handshake flow
    assign a_adv    = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !a_valid_reg || a_adv;
    assign s_accept = s_valid && s_ready;

    // write-back into the file happens as the item leaves the read stage
    assign rf_wr.en   = a_adv && alu_res.en;
    assign rf_wr.idx  = alu_res.idx;
    assign rf_wr.data = alu_res.data;

    mia_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rs_addr (s_src_reg),
        .rt_addr (s_tgt_reg),
        .wr      (rf_wr),
        .rs_data (rs_data),
        .rt_data (rt_data)
    );

    mia_alu u_alu (
        .mode   (a_mode_reg),
        .rs_val (rs_data),
        .rt_val (rt_data),
        .rt_idx (a_rt_idx_reg),
        .rd_idx (a_rd_idx_reg),
        .shamt  (a_shamt_reg),
        .imm    (a_imm_reg),
        .result (alu_res)
    );

    // read stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    // read stage payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_mode_reg   <= s_mode;
            a_rt_idx_reg <= s_tgt_reg;
            a_rd_idx_reg <= s_dst_reg;
            a_shamt_reg  <= s_shift_amount;
            a_imm_reg    <= s_immediate;
        end
    end

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (a_adv) begin
            m_wb_reg <= alu_res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_write_enable = m_wb_reg.en;
    assign m_write_index  = m_wb_reg.idx;
    assign m_write_value  = m_wb_reg.data;

    // register zero is never reported as written
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_wb_reg.en) |-> (m_wb_reg.idx != '0))
        else $error("write-back reported for register zero");

    // an item in the read stage that advances lands in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_adv |=> m_valid_reg)
        else $error("item lost between read stage and output register");

    // a stalled read-stage item is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !a_adv) |=> (a_valid_reg && $stable(a_mode_reg)))
        else $error("stalled read-stage item dropped or changed");

    // the file is only written when an item moves to the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        rf_wr.en |-> (a_valid_reg && (!m_valid_reg || m_ready)))
        else $error("register file written without an advancing item");

endmodule

/* design/mia_regfile.sv */
// ----------------------------------------------------------------------------
// mia_regfile
// 32 x 32 register file with two registered read ports, one write port,
// per-entry valid bits so reset reads as zero, and same-cycle write bypass.
// ----------------------------------------------------------------------------
module mia_regfile (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [mia_pkg::IDX_W-1:0]   rs_addr,
    input  logic [mia_pkg::IDX_W-1:0]   rt_addr,
    input  mia_pkg::wr_t                wr,
    output logic [mia_pkg::DATA_W-1:0]  rs_data,
    output logic [mia_pkg::DATA_W-1:0]  rt_data
);
    import mia_pkg::*;

    logic [DATA_W-1:0]    mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;

    logic [DATA_W-1:0] rs_mem_reg;
    logic [DATA_W-1:0] rt_mem_reg;
    logic [DATA_W-1:0] byp_data_reg;
    logic              rs_vld_reg;
    logic              rt_vld_reg;
    logic              rs_byp_reg;
    logic              rt_byp_reg;

    logic rs_hit;
    logic rt_hit;

    // a write landing on the same edge as the read wins
    assign rs_hit = wr.en && (wr.idx == rs_addr);
    assign rt_hit = wr.en && (wr.idx == rt_addr);

    // storage write, entry zero never gets written
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.idx] <= wr.data;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    // registered read ports
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rs_mem_reg   <= mem[rs_addr];
            rt_mem_reg   <= mem[rt_addr];
            byp_data_reg <= wr.data;
        end
    end

    // read select flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_vld_reg <= 1'b0;
            rt_vld_reg <= 1'b0;
            rs_byp_reg <= 1'b0;
            rt_byp_reg <= 1'b0;
        end else if (rd_en) begin
            rs_vld_reg <= valid_reg[rs_addr];
            rt_vld_reg <= valid_reg[rt_addr];
            rs_byp_reg <= rs_hit;
            rt_byp_reg <= rt_hit;
        end
    end

    // never-written entries read as zero
    assign rs_data = rs_byp_reg ? byp_data_reg :
                     (rs_vld_reg ? rs_mem_reg : '0);
    assign rt_data = rt_byp_reg ? byp_data_reg :
                     (rt_vld_reg ? rt_mem_reg : '0);

endmodule

/* design/mia_alu.sv */
// ----------------------------------------------------------------------------
// mia_alu
// Combinational integer ALU: shifts, add/sub, logic, set-less-than and the
// immediate forms, producing the write-back record.
// ----------------------------------------------------------------------------
module mia_alu (
    input  logic [mia_pkg::OP_W-1:0]    mode,
    input  logic [mia_pkg::DATA_W-1:0]  rs_val,
    input  logic [mia_pkg::DATA_W-1:0]  rt_val,
    input  logic [mia_pkg::IDX_W-1:0]   rt_idx,
    input  logic [mia_pkg::IDX_W-1:0]   rd_idx,
    input  logic [mia_pkg::SHAMT_W-1:0] shamt,
    input  logic [mia_pkg::IMM_W-1:0]   imm,
    output mia_pkg::wr_t                result
);
    import mia_pkg::*;

    logic [DATA_W-1:0]  simm;
    logic [DATA_W-1:0]  zimm;
    logic [SHAMT_W-1:0] vsh;
    logic [DATA_W-1:0]  val;
    logic [IDX_W-1:0]   dest;
    logic               active;

    // immediate extension and variable shift amount
    assign simm = {{(DATA_W-IMM_W){imm[IMM_W-1]}}, imm};
    assign zimm = {{(DATA_W-IMM_W){1'b0}}, imm};
    assign vsh  = rs_val[SHAMT_W-1:0] & SHIFT_MASK;

    // operation select
    always_comb begin
        val    = '0;
        dest   = '0;
        active = 1'b1;
        unique case (alu_op_t'(mode))
            OP_SLL: begin
                val = rt_val << shamt; dest = rd_idx;
            end
            OP_SRL: begin
                val = rt_val >> shamt; dest = rd_idx;
            end
            OP_SRA: begin
                val = DATA_W'($signed(rt_val) >>> shamt); dest = rd_idx;
            end
            OP_SLLV: begin
                val = rt_val << vsh; dest = rd_idx;
            end
            OP_SRLV: begin
                val = rt_val >> vsh; dest = rd_idx;
            end
            OP_SRAV: begin
                val = DATA_W'($signed(rt_val) >>> vsh); dest = rd_idx;
            end
            OP_ADDU: begin
                val = rs_val + rt_val; dest = rd_idx;
            end
            OP_SUBU: begin
                val = rs_val - rt_val; dest = rd_idx;
            end
            OP_AND: begin
                val = rs_val & rt_val; dest = rd_idx;
            end
            OP_OR: begin
                val = rs_val | rt_val; dest = rd_idx;
            end
            OP_XOR: begin
                val = rs_val ^ rt_val; dest = rd_idx;
            end
            OP_NOR: begin
                val = ~(rs_val | rt_val); dest = rd_idx;
            end
            OP_SLT: begin
                val  = DATA_W'($signed(rs_val) < $signed(rt_val));
                dest = rd_idx;
            end
            OP_SLTU: begin
                val = DATA_W'(rs_val < rt_val); dest = rd_idx;
            end
            OP_ADDIU: begin
                val = rs_val + simm; dest = rt_idx;
            end
            OP_SLTI: begin
                val  = DATA_W'($signed(rs_val) < $signed(simm));
                dest = rt_idx;
            end
            OP_SLTIU: begin
                val = DATA_W'(rs_val < simm); dest = rt_idx;
            end
            OP_ANDI: begin
                val = rs_val & zimm; dest = rt_idx;
            end
            OP_ORI: begin
                val = rs_val | zimm; dest = rt_idx;
            end
            OP_XORI: begin
                val = rs_val ^ zimm; dest = rt_idx;
            end
            OP_LUI: begin
                val = zimm << LUI_SHIFT; dest = rt_idx;
            end
            default: begin
                // nop and unused codes
                active = 1'b0;
            end
        endcase
    end

    // register zero is never written
    assign result.en   = active && (dest != '0);
    assign result.idx  = dest;
    assign result.data = val;

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the integer ALU execute block: instruction items
// go in through a queue-fed driver, write-back items are checked field by
// field against a shadow register file that executes every accepted item.
// ----------------------------------------------------------------------------
module tb;
    import mia_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RAND_ITEMS   = 550;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 10;
    localparam int RX_HOLD_LEN  = 64;
    localparam int RX_HOLD_AT   = 120;
    localparam int QUIET_LO     = 300;
    localparam int QUIET_HI     = 400;
    localparam int IDLE_PCT     = 23;

    // one instruction item plus a flag that makes the driver wait for drain
    typedef struct {
        logic [OP_W-1:0]    mode;
        logic [IDX_W-1:0]   src;
        logic [IDX_W-1:0]   tgt;
        logic [IDX_W-1:0]   dst;
        logic [SHAMT_W-1:0] shamt;
        logic [IMM_W-1:0]   imm;
        bit                 drain_before;
    } instr_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_mode         = '0;
    logic [IDX_W-1:0]    s_src_reg      = '0;
    logic [IDX_W-1:0]    s_tgt_reg      = '0;
    logic [IDX_W-1:0]    s_dst_reg      = '0;
    logic [SHAMT_W-1:0]  s_shift_amount = '0;
    logic [IMM_W-1:0]    s_immediate    = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic                m_write_enable;
    logic [IDX_W-1:0]    m_write_index;
    logic [DATA_W-1:0]   m_write_value;

    instr_t              pending_instr_q[$];
    wr_t                 wb_expect_q[$];
    logic [DATA_W-1:0]   shadow_rf[REG_COUNT];

    instr_t              next_instr;
    bit                  have_next      = 0;
    logic                in_taken       = 1'b0;
    int                  instr_total    = 0;
    int                  instr_taken    = 0;
    int                  wb_seen        = 0;
    int                  err_cnt        = 0;
    int                  stall_cycles   = 0;
    int                  rx_hold_left   = 0;
    bit                  rx_hold_done   = 0;

    mips_integer_alu_with_register_file DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_src_reg      (s_src_reg),
        .s_tgt_reg      (s_tgt_reg),
        .s_dst_reg      (s_dst_reg),
        .s_shift_amount (s_shift_amount),
        .s_immediate    (s_immediate),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_enable (m_write_enable),
        .m_write_index  (m_write_index),
        .m_write_value  (m_write_value)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // execute one instruction on the shadow register file, return its write-back
    function automatic wr_t exec_alu(logic [OP_W-1:0] mode, logic [IDX_W-1:0] src,
                                     logic [IDX_W-1:0] tgt, logic [IDX_W-1:0] dst,
                                     logic [SHAMT_W-1:0] shamt, logic [IMM_W-1:0] imm);
        logic [DATA_W-1:0]  rs;
        logic [DATA_W-1:0]  rt;
        logic [DATA_W-1:0]  simm;
        logic [DATA_W-1:0]  zimm;
        logic [SHAMT_W-1:0] vsh;
        logic [DATA_W-1:0]  val;
        logic [IDX_W-1:0]   dest;
        bit                 active;
        wr_t                wb;
        rs     = (src == '0) ? '0 : shadow_rf[src];
        rt     = (tgt == '0) ? '0 : shadow_rf[tgt];
        simm   = {{(DATA_W-IMM_W){imm[IMM_W-1]}}, imm};
        zimm   = DATA_W'(imm);
        vsh    = rs[SHAMT_W-1:0] & SHIFT_MASK;
        val    = '0;
        dest   = '0;
        active = 1;
        case (mode)
            OP_SLL:   begin val = rt << shamt; dest = dst; end
            OP_SRL:   begin val = rt >> shamt; dest = dst; end
            OP_SRA:   begin val = $signed(rt) >>> shamt; dest = dst; end
            OP_SLLV:  begin val = rt << vsh; dest = dst; end
            OP_SRLV:  begin val = rt >> vsh; dest = dst; end
            OP_SRAV:  begin val = $signed(rt) >>> vsh; dest = dst; end
            OP_ADDU:  begin val = rs + rt; dest = dst; end
            OP_SUBU:  begin val = rs - rt; dest = dst; end
            OP_AND:   begin val = rs & rt; dest = dst; end
            OP_OR:    begin val = rs | rt; dest = dst; end
            OP_XOR:   begin val = rs ^ rt; dest = dst; end
            OP_NOR:   begin val = ~(rs | rt); dest = dst; end
            OP_SLT:   begin val = DATA_W'($signed(rs) < $signed(rt)); dest = dst; end
            OP_SLTU:  begin val = DATA_W'(rs < rt); dest = dst; end
            OP_ADDIU: begin val = rs + simm; dest = tgt; end
            OP_SLTI:  begin val = DATA_W'($signed(rs) < $signed(simm)); dest = tgt; end
            OP_SLTIU: begin val = DATA_W'(rs < simm); dest = tgt; end
            OP_ANDI:  begin val = rs & zimm; dest = tgt; end
            OP_ORI:   begin val = rs | zimm; dest = tgt; end
            OP_XORI:  begin val = rs ^ zimm; dest = tgt; end
            OP_LUI:   begin val = zimm << LUI_SHIFT; dest = tgt; end
            default:  active = 0;
        endcase
        wb.en   = active && (dest != '0);
        wb.idx  = dest;
        wb.data = val;
        if (wb.en) begin
            shadow_rf[dest] = val;
        end
        return wb;
    endfunction

    task automatic push_instr(logic [OP_W-1:0] mode, logic [IDX_W-1:0] src,
                              logic [IDX_W-1:0] tgt, logic [IDX_W-1:0] dst,
                              logic [SHAMT_W-1:0] shamt, logic [IMM_W-1:0] imm);
        instr_t it;
        it.mode         = mode;
        it.src          = src;
        it.tgt          = tgt;
        it.dst          = dst;
        it.shamt        = shamt;
        it.imm          = imm;
        it.drain_before = 0;
        pending_instr_q.push_back(it);
        instr_total++;
    endtask

    // immediates lean toward the sign and range extremes
    function automatic logic [IMM_W-1:0] pick_imm();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return IMM_W'($urandom());
        endcase
    endfunction

    // stimulus and end of run
    initial begin
        for (int i = 0; i < REG_COUNT; i++) begin
            shadow_rf[i] = '0;
        end

        // seed registers with sign and range extremes
        push_instr(OP_LUI,   5'd0,  5'd1,  5'd0,  5'd0,  16'h8000);
        push_instr(OP_ADDIU, 5'd0,  5'd2,  5'd0,  5'd0,  16'hFFFF);
        push_instr(OP_ADDIU, 5'd1,  5'd3,  5'd0,  5'd0,  16'hFFFF);
        // shifts at the largest and smallest amounts
        push_instr(OP_SLL,   5'd0,  5'd2,  5'd4,  5'd31, 16'h0000);
        push_instr(OP_SRL,   5'd0,  5'd1,  5'd5,  5'd31, 16'h0000);
        push_instr(OP_SRA,   5'd0,  5'd1,  5'd6,  5'd31, 16'h0000);
        push_instr(OP_SLLV,  5'd2,  5'd2,  5'd7,  5'd0,  16'h0000);
        push_instr(OP_SRLV,  5'd3,  5'd1,  5'd8,  5'd0,  16'h0000);
        push_instr(OP_SRAV,  5'd0,  5'd1,  5'd9,  5'd0,  16'h0000);
        // arithmetic wrap and logic
        push_instr(OP_ADDU,  5'd2,  5'd2,  5'd10, 5'd0,  16'h0000);
        push_instr(OP_SUBU,  5'd0,  5'd2,  5'd11, 5'd0,  16'h0000);
        push_instr(OP_AND,   5'd1,  5'd3,  5'd12, 5'd0,  16'h0000);
        push_instr(OP_OR,    5'd1,  5'd3,  5'd13, 5'd0,  16'h0000);
        push_instr(OP_XOR,   5'd2,  5'd3,  5'd14, 5'd0,  16'h0000);
        push_instr(OP_NOR,   5'd0,  5'd0,  5'd15, 5'd0,  16'h0000);
        // signed against unsigned compares
        push_instr(OP_SLT,   5'd1,  5'd3,  5'd16, 5'd0,  16'h0000);
        push_instr(OP_SLTU,  5'd1,  5'd3,  5'd17, 5'd0,  16'h0000);
        push_instr(OP_SLTI,  5'd1,  5'd18, 5'd0,  5'd0,  16'h8000);
        // sltiu compares the sign-extended immediate as unsigned
        push_instr(OP_SLTIU, 5'd0,  5'd19, 5'd0,  5'd0,  16'hFFFF);
        push_instr(OP_ANDI,  5'd2,  5'd20, 5'd0,  5'd0,  16'hFFFF);
        push_instr(OP_ORI,   5'd1,  5'd21, 5'd0,  5'd0,  16'h7FFF);
        push_instr(OP_XORI,  5'd2,  5'd31, 5'd0,  5'd0,  16'h8000);
        // nop and unused codes, two of them with every other field at its maximum
        push_instr(OP_NOP,   5'd31, 5'd31, 5'd31, 5'd31, 16'hFFFF);
        push_instr(5'd22,    5'd2,  5'd2,  5'd5,  5'd3,  16'h1234);
        push_instr(5'd31,    5'd31, 5'd31, 5'd31, 5'd31, 16'hFFFF);
        // writes to register zero still report the computed value
        push_instr(OP_ADDU,  5'd2,  5'd2,  5'd0,  5'd0,  16'h0000);
        push_instr(OP_LUI,   5'd0,  5'd0,  5'd0,  5'd0,  16'hFFFF);

        // random part, mostly legal operations, a few unused codes
        for (int i = 0; i < RAND_ITEMS; i++) begin
            push_instr(($urandom_range(99) < 90) ? OP_W'($urandom_range(21))
                                                 : OP_W'($urandom_range(31, 22)),
                       IDX_W'($urandom()), IDX_W'($urandom()), IDX_W'($urandom()),
                       SHAMT_W'($urandom()), pick_imm());
            // sender pauses once until all write-backs are home
            if (i == 200) begin
                pending_instr_q[$].drain_before = 1;
            end
        end

        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        do begin
            @(negedge aclk);
        end while (instr_taken != instr_total || wb_expect_q.size() != 0);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (err_cnt == 0 && wb_expect_q.size() == 0) begin
            $display("mips_integer_alu_with_register_file test passed");
        end else begin
            $display("mips_integer_alu_with_register_file test failed");
        end
        $finish;
    end

    // instruction driver, changes inputs on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // hold the offered item
        end else begin
            if (!have_next && pending_instr_q.size() != 0) begin
                next_instr = pending_instr_q.pop_front();
                have_next  = 1;
            end
            if (!have_next) begin
                s_valid <= 1'b0;
            end else if (next_instr.drain_before && wb_expect_q.size() != 0) begin
                s_valid <= 1'b0;
            end else if (!(instr_taken >= QUIET_LO && instr_taken < QUIET_HI)
                         && $urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
            end else begin
                s_mode         <= next_instr.mode;
                s_src_reg      <= next_instr.src;
                s_tgt_reg      <= next_instr.tgt;
                s_dst_reg      <= next_instr.dst;
                s_shift_amount <= next_instr.shamt;
                s_immediate    <= next_instr.imm;
                s_valid        <= 1'b1;
                have_next       = 0;
            end
        end
    end

    // write-back ready, with one long hold to back the block up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!rx_hold_done && wb_seen >= RX_HOLD_AT) begin
                rx_hold_left = RX_HOLD_LEN;
                rx_hold_done = 1;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else if (wb_seen >= QUIET_LO && wb_seen < QUIET_HI) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // monitor: check write-backs, then predict from newly accepted items
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                wb_seen++;
                if (wb_expect_q.size() == 0) begin
                    $error("write-back item with nothing expected: en %b idx %0d value %h",
                           m_write_enable, m_write_index, m_write_value);
                    err_cnt++;
                end else begin
                    wr_t exp_wb;
                    exp_wb = wb_expect_q.pop_front();
                    if (m_write_enable !== exp_wb.en) begin
                        $error("write_enable: expected %b, got %b", exp_wb.en, m_write_enable);
                        err_cnt++;
                    end
                    if (m_write_index !== exp_wb.idx) begin
                        $error("write_index: expected %0d, got %0d",
                               exp_wb.idx, m_write_index);
                        err_cnt++;
                    end
                    if (m_write_value !== exp_wb.data) begin
                        $error("write_value: expected %h, got %h",
                               exp_wb.data, m_write_value);
                        err_cnt++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                instr_taken++;
                wb_expect_q.push_back(exec_alu(s_mode, s_src_reg, s_tgt_reg, s_dst_reg,
                                               s_shift_amount, s_immediate));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("mips_integer_alu_with_register_file test failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

endmodule
